// ===== design/thpq_pkg.sv =====
// Package for the ternary max-heap priority queue: payload structs, codes,
// derived widths and the controller/datapath command and status types.
// No dependencies.
package thpq_pkg;

    localparam int CAPACITY = 255;
    localparam int KEY_W    = 32;
    localparam int ENTRY_W  = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = SLOT_W + 2;
    localparam int PAR_W    = SLOT_W + 1;
    localparam int DIV3_SH  = PAR_W + 1;
    localparam logic [PAR_W-1:0] DIV3_MUL = PAR_W'(((1 << DIV3_SH) + 2) / 3);

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [SLOT_W-1:0]       slot_t;

    typedef struct packed {
        logic opcode;
        key_t key;
    } cmd_t;

    typedef struct packed {
        key_t                max_key;
        logic [STATUS_W-1:0] status;
        logic [ENTRY_W-1:0]  entry_count;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CHK,
        ST_UP_WAIT,
        ST_EX_ROOT,
        ST_EX_LAST,
        ST_DN_START,
        ST_DN_CMP,
        ST_DN_MOVE,
        ST_RESULT
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_PARENT,
        RD_ROOT,
        RD_LAST,
        RD_CHILD0,
        RD_CHILD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_RDATA,
        WR_BEST
    } wr_sel_t;

    typedef struct packed {
        logic    accept;
        logic    ins_grow;
        logic    set_full;
        logic    set_empty;
        logic    cap_root;
        logic    cap_last;
        logic    dn_init;
        logic    dn_cmp;
        logic    pos_to_parent;
        logic    pos_to_best;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic op_extract;
        logic full;
        logic empty;
        logic pos_is_root;
        logic key_gt_rdata;
        logic child0_ok;
        logic next_ok;
        logic best_moved;
    } dp_stat_t;

endpackage

// ===== design/thpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module thpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/thpq_ctrl.sv =====
// Controller for the ternary heap queue: sequences insert sift-up and
// extract sift-down. Depends on thpq_pkg.
module thpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  thpq_pkg::dp_stat_t stat,
    output thpq_pkg::dp_cmd_t  ctl,
    output logic               busy,
    output logic               done
);

    thpq_pkg::state_t state_reg;
    thpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= thpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            thpq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctl.accept = 1'b1;
                    if (!stat.op_extract)
                    begin
                        if (stat.full)
                        begin
                            ctl.set_full = 1'b1;
                            state_next   = thpq_pkg::ST_RESULT;
                        end
                        else
                        begin
                            ctl.ins_grow = 1'b1;
                            state_next   = thpq_pkg::ST_UP_CHK;
                        end
                    end
                    else if (stat.empty)
                    begin
                        ctl.set_empty = 1'b1;
                        state_next    = thpq_pkg::ST_RESULT;
                    end
                    else
                    begin
                        ctl.rd_sel = thpq_pkg::RD_ROOT;
                        state_next = thpq_pkg::ST_EX_ROOT;
                    end
                end
            end
            thpq_pkg::ST_UP_CHK:
            begin
                if (stat.pos_is_root)
                begin
                    ctl.wr_sel = thpq_pkg::WR_KEY;
                    state_next = thpq_pkg::ST_RESULT;
                end
                else
                begin
                    ctl.rd_sel = thpq_pkg::RD_PARENT;
                    state_next = thpq_pkg::ST_UP_WAIT;
                end
            end
            thpq_pkg::ST_UP_WAIT:
            begin
                if (stat.key_gt_rdata)
                begin
                    ctl.wr_sel        = thpq_pkg::WR_RDATA;
                    ctl.pos_to_parent = 1'b1;
                    state_next        = thpq_pkg::ST_UP_CHK;
                end
                else
                begin
                    ctl.wr_sel = thpq_pkg::WR_KEY;
                    state_next = thpq_pkg::ST_RESULT;
                end
            end
            thpq_pkg::ST_EX_ROOT:
            begin
                ctl.cap_root = 1'b1;
                ctl.rd_sel   = thpq_pkg::RD_LAST;
                state_next   = thpq_pkg::ST_EX_LAST;
            end
            thpq_pkg::ST_EX_LAST:
            begin
                ctl.cap_last = 1'b1;
                state_next   = thpq_pkg::ST_DN_START;
            end
            thpq_pkg::ST_DN_START:
            begin
                ctl.dn_init = 1'b1;
                if (stat.child0_ok)
                begin
                    ctl.rd_sel = thpq_pkg::RD_CHILD0;
                    state_next = thpq_pkg::ST_DN_CMP;
                end
                else
                begin
                    ctl.wr_sel = thpq_pkg::WR_KEY;
                    state_next = thpq_pkg::ST_RESULT;
                end
            end
            thpq_pkg::ST_DN_CMP:
            begin
                ctl.dn_cmp = 1'b1;
                if (stat.next_ok)
                begin
                    ctl.rd_sel = thpq_pkg::RD_CHILD_NEXT;
                end
                else
                begin
                    state_next = thpq_pkg::ST_DN_MOVE;
                end
            end
            thpq_pkg::ST_DN_MOVE:
            begin
                if (stat.best_moved)
                begin
                    ctl.wr_sel      = thpq_pkg::WR_BEST;
                    ctl.pos_to_best = 1'b1;
                    state_next      = thpq_pkg::ST_DN_START;
                end
                else
                begin
                    ctl.wr_sel = thpq_pkg::WR_KEY;
                    state_next = thpq_pkg::ST_RESULT;
                end
            end
            thpq_pkg::ST_RESULT:
            begin
                state_next = thpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = thpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != thpq_pkg::ST_IDLE);
    assign done = (state_reg == thpq_pkg::ST_RESULT);

endmodule

// ===== design/thpq_dp.sv =====
// Datapath for the ternary heap queue: heap RAM, fill count, hole position,
// moving key, child scan and result registers. Depends on thpq_pkg, thpq_ram.
module thpq_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  thpq_pkg::cmd_t     cmd,
    input  thpq_pkg::dp_cmd_t  ctl,
    output thpq_pkg::dp_stat_t stat,
    output thpq_pkg::result_t  result
);

    localparam logic [1:0] CIDX_LAST = 2'd2;

    thpq_pkg::slot_t fill_reg;
    thpq_pkg::slot_t pos_reg;
    thpq_pkg::slot_t best_slot_reg;
    logic [1:0]      cidx_reg;
    thpq_pkg::key_t  key_reg;
    thpq_pkg::key_t  best_key_reg;
    thpq_pkg::key_t  max_reg;
    logic [thpq_pkg::STATUS_W-1:0] status_reg;

    logic [thpq_pkg::KEY_W-1:0]     ram_rdata;
    logic [thpq_pkg::KEY_W-1:0]     ram_wdata;
    thpq_pkg::slot_t                ram_raddr;
    logic                           ram_re;
    logic                           ram_we;

    logic [thpq_pkg::CHILD_W-1:0]   fill_ext;
    logic [thpq_pkg::CHILD_W-1:0]   child_base;
    logic [thpq_pkg::CHILD_W-1:0]   child_cur;
    logic [thpq_pkg::CHILD_W-1:0]   child_next;
    logic [thpq_pkg::PAR_W-1:0]     par_num;
    logic [2*thpq_pkg::PAR_W-1:0]   par_prod;
    thpq_pkg::slot_t                parent;
    logic                           child_gt;

    assign fill_ext   = thpq_pkg::CHILD_W'(fill_reg);
    assign child_base = thpq_pkg::CHILD_W'(pos_reg) + {1'b0, pos_reg, 1'b0}
                        - thpq_pkg::CHILD_W'(1);
    assign child_cur  = child_base + thpq_pkg::CHILD_W'(cidx_reg);
    assign child_next = child_cur + thpq_pkg::CHILD_W'(1);

    assign par_num  = thpq_pkg::PAR_W'(pos_reg) + thpq_pkg::PAR_W'(1);
    assign par_prod = par_num * thpq_pkg::DIV3_MUL;
    assign parent   = par_prod[thpq_pkg::DIV3_SH +: thpq_pkg::SLOT_W];

    assign child_gt = $signed(ram_rdata) > best_key_reg;

    always_comb
    begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        unique case (ctl.rd_sel)
            thpq_pkg::RD_NONE:       ram_re    = 1'b0;
            thpq_pkg::RD_PARENT:     ram_raddr = parent;
            thpq_pkg::RD_ROOT:       ram_raddr = thpq_pkg::SLOT_W'(1);
            thpq_pkg::RD_LAST:       ram_raddr = fill_reg;
            thpq_pkg::RD_CHILD0:     ram_raddr = child_base[thpq_pkg::SLOT_W-1:0];
            thpq_pkg::RD_CHILD_NEXT: ram_raddr = child_next[thpq_pkg::SLOT_W-1:0];
            default:                 ram_re    = 1'b0;
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b1;
        ram_wdata = key_reg;
        unique case (ctl.wr_sel)
            thpq_pkg::WR_NONE:  ram_we    = 1'b0;
            thpq_pkg::WR_KEY:   ram_wdata = key_reg;
            thpq_pkg::WR_RDATA: ram_wdata = ram_rdata;
            thpq_pkg::WR_BEST:  ram_wdata = best_key_reg;
            default:            ram_we    = 1'b0;
        endcase
    end

    thpq_ram #(
        .WIDTH (thpq_pkg::KEY_W),
        .DEPTH (thpq_pkg::CAPACITY + 1)
    ) u_heap_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            cidx_reg <= '0;
        end
        else
        begin
            if (ctl.ins_grow)
            begin
                fill_reg <= fill_reg + thpq_pkg::SLOT_W'(1);
                pos_reg  <= fill_reg + thpq_pkg::SLOT_W'(1);
            end
            else if (ctl.cap_last)
            begin
                fill_reg <= fill_reg - thpq_pkg::SLOT_W'(1);
                pos_reg  <= thpq_pkg::SLOT_W'(1);
            end
            else if (ctl.pos_to_parent)
            begin
                pos_reg <= parent;
            end
            else if (ctl.pos_to_best)
            begin
                pos_reg <= best_slot_reg;
            end
            if (ctl.dn_init)
            begin
                cidx_reg <= '0;
            end
            else if (ctl.dn_cmp)
            begin
                cidx_reg <= cidx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            key_reg <= cmd.key;
            max_reg <= '0;
            if (ctl.set_full)
            begin
                status_reg <= thpq_pkg::STATUS_FULL;
            end
            else if (ctl.set_empty)
            begin
                status_reg <= thpq_pkg::STATUS_EMPTY;
            end
            else
            begin
                status_reg <= thpq_pkg::STATUS_OK;
            end
        end
        if (ctl.cap_root)
        begin
            max_reg <= $signed(ram_rdata);
        end
        if (ctl.cap_last)
        begin
            key_reg <= $signed(ram_rdata);
        end
        if (ctl.dn_init)
        begin
            best_slot_reg <= pos_reg;
            best_key_reg  <= key_reg;
        end
        else if (ctl.dn_cmp && child_gt)
        begin
            best_slot_reg <= child_cur[thpq_pkg::SLOT_W-1:0];
            best_key_reg  <= $signed(ram_rdata);
        end
    end

    always_comb
    begin
        stat.op_extract   = (cmd.opcode == thpq_pkg::OP_EXTRACT);
        stat.full         = (fill_reg == thpq_pkg::SLOT_W'(thpq_pkg::CAPACITY));
        stat.empty        = (fill_reg == '0);
        stat.pos_is_root  = (pos_reg == thpq_pkg::SLOT_W'(1));
        stat.key_gt_rdata = key_reg > $signed(ram_rdata);
        stat.child0_ok    = (child_base <= fill_ext);
        stat.next_ok      = (cidx_reg != CIDX_LAST) && (child_next <= fill_ext);
        stat.best_moved   = (best_slot_reg != pos_reg);
    end

    assign result.max_key     = max_reg;
    assign result.status      = status_reg;
    assign result.entry_count = thpq_pkg::ENTRY_W'(fill_reg);

endmodule

// ===== design/ternary_heap_priority_queue_unit.sv =====
// Top level of the ternary max-heap priority queue.
// Depends on thpq_pkg, thpq_ctrl, thpq_dp (which holds thpq_ram).
//
// One command beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on result for the single cycle in which done is
// high, and the receiver must take it then. Work is one item at a time through
// a single-port-read heap RAM. A refused insert or extract goes straight to
// the result beat; an insert climbs one parent read and compare per level,
// and an extract reads the root and the last entry, then scans up to three
// children per level. The heap RAM needs no clearing after reset; the fill
// count, hole position, child index and controller state reset, while the
// key and result registers do not.
module ternary_heap_priority_queue_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  thpq_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output thpq_pkg::result_t result
);

    thpq_pkg::dp_cmd_t  ctl;
    thpq_pkg::dp_stat_t stat;

    thpq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    thpq_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .ctl    (ctl),
        .stat   (stat),
        .result (result)
    );

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("result beat not followed by idle");

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == thpq_pkg::STATUS_FULL)) |->
        (result.entry_count == thpq_pkg::ENTRY_W'(thpq_pkg::CAPACITY)))
        else $error("full refusal with queue not full");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == thpq_pkg::STATUS_EMPTY)) |->
        ((result.entry_count == '0) && (result.max_key == '0)))
        else $error("empty refusal with nonzero count or key");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ternary_heap_priority_queue_unit: inserts and
// extract-max beats against a local ternary max-heap predictor.
// Depends on thpq_pkg and the design top level.
module testbench;

    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  REPORT_LINES = 40;
    localparam thpq_pkg::key_t KEY_MAX = 32'sh7FFF_FFFF;
    localparam thpq_pkg::key_t KEY_MIN = 32'sh8000_0000;

    typedef struct {
        thpq_pkg::cmd_t beat;
        int unsigned    idle_pct;
    } queued_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    thpq_pkg::cmd_t    cmd = '0;
    logic              busy;
    logic              done;
    thpq_pkg::result_t result;

    queued_beat_t      pending_beats[$];
    thpq_pkg::result_t expected_results[$];

    thpq_pkg::key_t heap_img[1:thpq_pkg::CAPACITY];
    int unsigned heap_fill;
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned insert_count;
    int unsigned extract_count;
    int unsigned full_refusals;
    int unsigned empty_refusals;
    int unsigned peak_fill;
    int unsigned checked_count;

    ternary_heap_priority_queue_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic void swap_heap(int unsigned a, int unsigned b);
        thpq_pkg::key_t t;
        t = heap_img[a];
        heap_img[a] = heap_img[b];
        heap_img[b] = t;
    endfunction

    function automatic thpq_pkg::result_t predict_heap_op(thpq_pkg::cmd_t beat);
        thpq_pkg::result_t res;
        int unsigned pos;
        int unsigned up;
        int unsigned best;
        int unsigned first;
        res = '0;
        res.status = thpq_pkg::STATUS_OK;
        if (beat.opcode == thpq_pkg::OP_INSERT)
        begin
            if (heap_fill >= thpq_pkg::CAPACITY)
            begin
                res.status = thpq_pkg::STATUS_FULL;
                full_refusals++;
            end
            else
            begin
                heap_fill++;
                heap_img[heap_fill] = beat.key;
                pos = heap_fill;
                while (pos > 1)
                begin
                    up = (pos + 1) / 3;
                    if (!(heap_img[pos] > heap_img[up]))
                        break;
                    swap_heap(pos, up);
                    pos = up;
                end
                insert_count++;
                if (heap_fill > peak_fill)
                    peak_fill = heap_fill;
            end
        end
        else
        begin
            if (heap_fill == 0)
            begin
                res.status = thpq_pkg::STATUS_EMPTY;
                empty_refusals++;
            end
            else
            begin
                res.max_key = heap_img[1];
                heap_img[1] = heap_img[heap_fill];
                heap_fill--;
                pos = 1;
                forever
                begin
                    best = pos;
                    first = 3 * pos - 1;
                    for (int unsigned c = first; c <= first + 2; c++)
                    begin
                        if (c <= heap_fill && heap_img[c] > heap_img[best])
                            best = c;
                    end
                    if (best == pos)
                        break;
                    swap_heap(best, pos);
                    pos = best;
                end
                extract_count++;
            end
        end
        res.entry_count = heap_fill[thpq_pkg::ENTRY_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < REPORT_LINES)
            $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        mismatch_count++;
    endtask

    // Driver: take the beat on an accepting edge, then offer the next one.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.push_back(predict_heap_op(cmd));
                void'(pending_beats.pop_front());
            end
            if (!(start && busy))
            begin
                if (pending_beats.size() > 0 &&
                    $urandom_range(99) >= pending_beats[0].idle_pct)
                begin
                    start <= 1'b1;
                    cmd   <= pending_beats[0].beat;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result beat, status", result.status, -1);
            end
            else
            begin
                if (result.max_key !== expected_results[0].max_key)
                    report_mismatch("max_key", result.max_key,
                                    expected_results[0].max_key);
                if (result.status !== expected_results[0].status)
                    report_mismatch("status", result.status,
                                    expected_results[0].status);
                if (result.entry_count !== expected_results[0].entry_count)
                    report_mismatch("entry_count", result.entry_count,
                                    expected_results[0].entry_count);
                void'(expected_results.pop_front());
                checked_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic add_beat(logic op, thpq_pkg::key_t key, int unsigned idle_pct);
        queued_beat_t qb;
        qb.beat.opcode = op;
        qb.beat.key    = key;
        qb.idle_pct    = idle_pct;
        pending_beats.push_back(qb);
    endtask

    function automatic thpq_pkg::key_t pick_key();
        case ($urandom_range(9))
            0, 1:    return thpq_pkg::key_t'($signed($urandom_range(8)) - 4);
            2:
            begin
                case ($urandom_range(4))
                    0:       return KEY_MAX;
                    1:       return KEY_MIN;
                    2:       return '0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            default: return thpq_pkg::key_t'($urandom);
        endcase
    endfunction

    // Mix of inserts and extracts in runs of 40 beats, each with its own insert share.
    task automatic add_mix(int unsigned n, int unsigned idle_pct);
        int unsigned ins_pct;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(3))
                    0:       ins_pct = 30;
                    1:       ins_pct = 50;
                    2:       ins_pct = 70;
                    default: ins_pct = 85;
                endcase
            end
            if ($urandom_range(99) < ins_pct)
                add_beat(thpq_pkg::OP_INSERT, pick_key(), idle_pct);
            else
                add_beat(thpq_pkg::OP_EXTRACT, thpq_pkg::key_t'($urandom), idle_pct);
        end
    endtask

    initial
    begin
        heap_fill = 0;
        mismatch_count = 0;
        cycle_count = 0;
        insert_count = 0;
        extract_count = 0;
        full_refusals = 0;
        empty_refusals = 0;
        peak_fill = 0;
        checked_count = 0;

        add_beat(thpq_pkg::OP_EXTRACT, KEY_MAX, 0);
        add_beat(thpq_pkg::OP_INSERT, KEY_MAX, 0);
        add_beat(thpq_pkg::OP_EXTRACT, '0, 0);
        add_beat(thpq_pkg::OP_EXTRACT, KEY_MIN, 0);
        add_beat(thpq_pkg::OP_INSERT, KEY_MIN, 0);
        add_beat(thpq_pkg::OP_INSERT, KEY_MAX, 0);
        add_beat(thpq_pkg::OP_INSERT, '0, 0);
        add_beat(thpq_pkg::OP_INSERT, -1, 0);
        add_beat(thpq_pkg::OP_INSERT, 1, 0);
        add_beat(thpq_pkg::OP_INSERT, KEY_MAX, 0);
        add_beat(thpq_pkg::OP_INSERT, KEY_MIN, 0);
        for (int i = 0; i < 8; i++)
            add_beat(thpq_pkg::OP_EXTRACT, '1, 0);
        for (int i = 0; i < 4; i++)
            add_beat(thpq_pkg::OP_INSERT, 5, 0);
        add_beat(thpq_pkg::OP_EXTRACT, '0, 0);
        add_beat(thpq_pkg::OP_EXTRACT, '0, 0);

        add_mix(300, 0);
        add_mix(260, 59);
        // Fill past capacity, then drain past empty.
        for (int i = 0; i < 258; i++)
            add_beat(thpq_pkg::OP_INSERT, pick_key(), 0);
        for (int i = 0; i < 262; i++)
            add_beat(thpq_pkg::OP_EXTRACT, thpq_pkg::key_t'($urandom), 0);
        add_mix(250, 30);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results: %0d inserts, %0d extracts, peak fill %0d",
                 checked_count, insert_count, extract_count, peak_fill);
        $display("refused on full queue %0d, on empty queue %0d, mismatches %0d",
                 full_refusals, empty_refusals, mismatch_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
